// ----- sv/sldm_pkg.sv -----
// shared types, codes and constants for the sorted list difference merge
`timescale 1ns / 1ps

package sldm_pkg;

   localparam int LIST_DEPTH_DEF = 64;
   localparam int REC_W          = 31;
   localparam int WT_W           = 32;

   typedef enum logic [1:0] {
      CMD_LOAD_A = 2'd0,
      CMD_LOAD_B = 2'd1,
      CMD_RUN    = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [1:0]       cmd;
      logic [REC_W-1:0] record_id;
      logic [WT_W-1:0]  weight_bits;
   } req_type;

   typedef struct packed {
      logic [REC_W-1:0] out_record;
      logic [WT_W-1:0]  out_weight;
      logic             is_last;
      logic             is_empty;
      logic             overflowed;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_FLUSH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic start;
      logic adv_a;
      logic adv_b;
      logic emit;
      logic flush;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic a_done;
      logic b_done;
      logic a_gt_b;
      logic a_eq_b;
      logic out_free;
      logic pend_valid;
   } dp_status_type;

endpackage

// ----- sv/sorted_list_difference_merge.sv -----
// top level of the sorted list difference (and-not) merge block
`timescale 1ns / 1ps

// Loads for list A (record and weight) and list B (record) are taken one per
// cycle while idle and written at each list's fill count; loads past LIST_DEPTH
// are dropped and raise the overflowed flag on the next run's results. A run
// request walks both lists with two pointers, each pointer step going through
// a read state (the registered list memory read) and then a compare state; a
// full output register stalls the walk. Requests are not accepted during a
// run. Every A entry whose record is not matched in B comes out in order, the
// last one marked; a run with no survivor gives a single result flagged empty.
// Both lists and the overflow flag are cleared when a run ends.

module sorted_list_difference_merge #(
   parameter int LIST_DEPTH = sldm_pkg::LIST_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sldm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sldm_pkg::rsp_type rsp_data
);
   import sldm_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type status;

   sldm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_data.cmd),
      .req_ready (req_ready),
      .status    (status),
      .dp_cmd    (dp_cmd)
   );

   sldm_dp #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .dp_cmd    (dp_cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- sv/sldm_ctrl.sv -----
// controller state machine for the two-pointer merge walk
`timescale 1ns / 1ps

module sldm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_cmd,
   output logic                   req_ready,
   input  sldm_pkg::dp_status_type status,
   output sldm_pkg::dp_cmd_type   dp_cmd
);
   import sldm_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      take_a;

   // a entry survives when b is exhausted or a's record is below b's
   assign take_a = status.b_done || (!status.a_gt_b && !status.a_eq_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_cmd == CMD_RUN)) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (status.a_done) begin
               state_in = ST_FLUSH;
            end else begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (!(take_a && status.pend_valid && !status.out_free)) begin
               state_in = ST_READ;
            end
         end
         ST_FLUSH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      dp_cmd    = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            dp_cmd.load  = req_valid && ((req_cmd == CMD_LOAD_A) || (req_cmd == CMD_LOAD_B));
            dp_cmd.start = req_valid && (req_cmd == CMD_RUN);
         end
         ST_READ: begin
            dp_cmd = '0;
         end
         ST_CMP: begin
            if (take_a) begin
               if (!(status.pend_valid && !status.out_free)) begin
                  dp_cmd.emit  = 1'b1;
                  dp_cmd.adv_a = 1'b1;
               end
            end else if (status.a_gt_b) begin
               dp_cmd.adv_b = 1'b1;
            end else begin
               dp_cmd.adv_a = 1'b1;
               dp_cmd.adv_b = 1'b1;
            end
         end
         ST_FLUSH: begin
            dp_cmd.flush = status.out_free;
         end
         default: dp_cmd = '0;
      endcase
   end

endmodule

// ----- sv/sldm_dp.sv -----
// list memories, counts, pointers, pending result and output register
`timescale 1ns / 1ps

module sldm_dp #(
   parameter int LIST_DEPTH = sldm_pkg::LIST_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  sldm_pkg::req_type       req_data,
   input  sldm_pkg::dp_cmd_type    dp_cmd,
   output sldm_pkg::dp_status_type status,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output sldm_pkg::rsp_type       rsp_data
);
   import sldm_pkg::*;

   localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CW = $clog2(LIST_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

   logic [REC_W-1:0] a_rec_mem [LIST_DEPTH];
   logic [WT_W-1:0]  a_wt_mem  [LIST_DEPTH];
   logic [REC_W-1:0] b_rec_mem [LIST_DEPTH];

   logic [CW-1:0]    a_count_ff, a_count_in;
   logic [CW-1:0]    b_count_ff, b_count_in;
   logic             ovf_ff, ovf_in;
   logic [CW-1:0]    ia_ff, ia_in;
   logic [CW-1:0]    ib_ff, ib_in;

   logic [REC_W-1:0] ra_ff;
   logic [WT_W-1:0]  wa_ff;
   logic [REC_W-1:0] rb_ff;

   logic [REC_W-1:0] pend_rec_ff;
   logic [WT_W-1:0]  pend_wt_ff;
   logic             pend_valid_ff, pend_valid_in;

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;
   logic             out_free;
   logic             wr_a, wr_b;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign wr_a = dp_cmd.load && (req_data.cmd == CMD_LOAD_A) && (a_count_ff < DEPTH_C);
   assign wr_b = dp_cmd.load && (req_data.cmd == CMD_LOAD_B) && (b_count_ff < DEPTH_C);

   // memories: write at the fill count, registered read at the walk pointers
   always_ff @(posedge clock) begin
      if (wr_a) begin
         a_rec_mem[a_count_ff[AW-1:0]] <= req_data.record_id;
         a_wt_mem[a_count_ff[AW-1:0]]  <= req_data.weight_bits;
      end
      if (wr_b) begin
         b_rec_mem[b_count_ff[AW-1:0]] <= req_data.record_id;
      end
      ra_ff <= a_rec_mem[ia_ff[AW-1:0]];
      wa_ff <= a_wt_mem[ia_ff[AW-1:0]];
      rb_ff <= b_rec_mem[ib_ff[AW-1:0]];
   end

   always_comb begin
      a_count_in = a_count_ff;
      b_count_in = b_count_ff;
      ovf_in     = ovf_ff;
      ia_in      = ia_ff;
      ib_in      = ib_ff;
      if (wr_a) begin
         a_count_in = a_count_ff + 1'b1;
      end
      if (wr_b) begin
         b_count_in = b_count_ff + 1'b1;
      end
      if (dp_cmd.load && !wr_a && !wr_b) begin
         ovf_in = 1'b1;
      end
      if (dp_cmd.start) begin
         ia_in = '0;
         ib_in = '0;
      end
      if (dp_cmd.adv_a) begin
         ia_in = ia_ff + 1'b1;
      end
      if (dp_cmd.adv_b) begin
         ib_in = ib_ff + 1'b1;
      end
      if (dp_cmd.flush) begin
         a_count_in = '0;
         b_count_in = '0;
         ovf_in     = 1'b0;
      end
   end

   // results lag by one survivor so the final one can carry is_last
   always_comb begin
      pend_valid_in = pend_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      if (dp_cmd.emit) begin
         pend_valid_in = 1'b1;
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{out_record: pend_rec_ff, out_weight: pend_wt_ff,
                             is_last: 1'b0, is_empty: 1'b0, overflowed: ovf_ff};
         end
      end
      if (dp_cmd.flush) begin
         pend_valid_in = 1'b0;
         rsp_valid_in  = 1'b1;
         if (pend_valid_ff) begin
            rsp_data_in = '{out_record: pend_rec_ff, out_weight: pend_wt_ff,
                            is_last: 1'b1, is_empty: 1'b0, overflowed: ovf_ff};
         end else begin
            rsp_data_in = '{out_record: '0, out_weight: '0,
                            is_last: 1'b1, is_empty: 1'b1, overflowed: ovf_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_count_ff    <= '0;
         b_count_ff    <= '0;
         ovf_ff        <= 1'b0;
         ia_ff         <= '0;
         ib_ff         <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         a_count_ff    <= a_count_in;
         b_count_ff    <= b_count_in;
         ovf_ff        <= ovf_in;
         ia_ff         <= ia_in;
         ib_ff         <= ib_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.emit) begin
         pend_rec_ff <= ra_ff;
         pend_wt_ff  <= wa_ff;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign status.a_done     = (ia_ff >= a_count_ff);
   assign status.b_done     = (ib_ff >= b_count_ff);
   assign status.a_gt_b     = (ra_ff > rb_ff);
   assign status.a_eq_b     = (ra_ff == rb_ff);
   assign status.out_free   = out_free;
   assign status.pend_valid = pend_valid_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
